// ===== rtl/psfp_pkg.sv =====
// shared constants, types and codes of the particle sensor frame parser
package psfp_pkg;

   // frame buffer length and checksum span, in bytes
   localparam int BUFFER_DEPTH = 64;
   localparam int SUM_SPAN     = 20;
   localparam int POS_W        = $clog2(BUFFER_DEPTH);

   // field widths
   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 16;

   // item kind codes carried on tuser
   localparam logic KIND_DATA      = 1'b0;
   localparam logic KIND_BURST_END = 1'b1;

   // frame header bytes and positions of the reading
   localparam logic [BYTE_W-1:0] HDR0 = 8'h16;
   localparam logic [BYTE_W-1:0] HDR1 = 8'h11;
   localparam logic [BYTE_W-1:0] HDR2 = 8'h0B;
   localparam int POS_HDR0 = 0;
   localparam int POS_HDR1 = 1;
   localparam int POS_HDR2 = 2;
   localparam int POS_HI   = 5;
   localparam int POS_LO   = 6;

   // one input word as held in the input register
   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] rx_byte;
   } item_type;

   // outcome of checking a burst end against the frame state
   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] value;
   } check_type;

endpackage

// ===== rtl/psfp_in_stage.sv =====
// input register stage of the frame parser
module psfp_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,  // [7:0] rx_byte
   input  logic                      req_tuser,  // [0] kind
   input  logic                      advance,
   output logic                      item_valid,
   output psfp_pkg::item_type        item
);

   logic               valid_ff;
   logic               valid_in;
   psfp_pkg::item_type item_ff;
   logic               accept;

   // free when empty or when the held word moves on this cycle
   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind    <= req_tuser;
         item_ff.rx_byte <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/psfp_frame.sv =====
// frame state: byte position, captured bytes, running sum and frame check
module psfp_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  psfp_pkg::item_type   item,
   output psfp_pkg::check_type  check
);

   localparam int PW = psfp_pkg::POS_W;
   localparam int BW = psfp_pkg::BYTE_W;

   logic [PW-1:0] pos_ff, pos_in;
   logic [BW-1:0] hdr0_ff, hdr0_in;
   logic [BW-1:0] hdr1_ff, hdr1_in;
   logic [BW-1:0] hdr2_ff, hdr2_in;
   logic [BW-1:0] hi_ff, hi_in;
   logic [BW-1:0] lo_ff, lo_in;
   logic [BW-1:0] sum_ff, sum_in;
   logic          in_span;
   logic          last_pos;

   assign in_span  = {1'b0, pos_ff} < (PW+1)'(psfp_pkg::SUM_SPAN);
   assign last_pos = pos_ff == PW'(psfp_pkg::BUFFER_DEPTH - 1);

   // frame check on the current state
   assign check.hit = (hdr0_ff == psfp_pkg::HDR0) && (hdr1_ff == psfp_pkg::HDR1) &&
                      (hdr2_ff == psfp_pkg::HDR2) && (sum_ff == '0);
   assign check.value = {hi_ff, lo_ff};

   // next state for one word
   always_comb begin
      pos_in  = pos_ff;
      hdr0_in = hdr0_ff;
      hdr1_in = hdr1_ff;
      hdr2_in = hdr2_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      sum_in  = sum_ff;
      if (step) begin
         if (item.kind == psfp_pkg::KIND_BURST_END || last_pos) begin
            // burst end or buffer full: start a fresh frame
            pos_in  = '0;
            hdr0_in = '0;
            hdr1_in = '0;
            hdr2_in = '0;
            hi_in   = '0;
            lo_in   = '0;
            sum_in  = '0;
         end else begin
            if (pos_ff == PW'(psfp_pkg::POS_HDR0)) hdr0_in = item.rx_byte;
            if (pos_ff == PW'(psfp_pkg::POS_HDR1)) hdr1_in = item.rx_byte;
            if (pos_ff == PW'(psfp_pkg::POS_HDR2)) hdr2_in = item.rx_byte;
            if (pos_ff == PW'(psfp_pkg::POS_HI))   hi_in   = item.rx_byte;
            if (pos_ff == PW'(psfp_pkg::POS_LO))   lo_in   = item.rx_byte;
            if (in_span) sum_in = sum_ff + item.rx_byte;
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         hdr0_ff <= '0;
         hdr1_ff <= '0;
         hdr2_ff <= '0;
         hi_ff   <= '0;
         lo_ff   <= '0;
         sum_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         hdr0_ff <= hdr0_in;
         hdr1_ff <= hdr1_in;
         hdr2_ff <= hdr2_in;
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

// ===== rtl/psfp_rsp_reg.sv =====
// result register of the frame parser
module psfp_rsp_reg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [psfp_pkg::VALUE_W-1:0] value,
   output logic                         free,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [15:0]                  rsp_tdata   // [15:0] pm25_value
);

   logic                         valid_ff, valid_in;
   logic [psfp_pkg::VALUE_W-1:0] data_ff;

   // room when empty or when the held word leaves this cycle
   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= value;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== rtl/particle_sensor_frame_parser_core.sv =====
// top level of the particle sensor frame parser
// Each word on the request side is a received sensor byte (tuser low) or a
// burst-end marker (tuser high). Bytes are counted into a 64-byte frame
// buffer; bytes 0 to 2 are the header, bytes 5 and 6 the PM2.5 reading, and
// an 8-bit wrapping sum covers bytes 0 to 19. A burst end whose header reads
// 16 11 0B and whose sum is zero yields one response word with the reading
// (byte 5 high, byte 6 low); every burst end, and a full buffer, restarts the
// frame. One word is taken per clock while no stall holds: a word goes through
// an input register, the frame update and check, and a response register, so
// a result is offered on the response side once its burst end has moved on
// from the input register. Backpressure on the response side stalls the
// request side only while a result waits to be taken.
module particle_sensor_frame_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] pm25_value
);

   logic                item_valid;
   psfp_pkg::item_type  item;
   psfp_pkg::check_type check;
   logic                out_free;
   logic                emit;
   logic                advance;

   psfp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // a burst end with a good frame needs room in the response register
   assign emit    = item_valid && (item.kind == psfp_pkg::KIND_BURST_END) && check.hit;
   assign advance = item_valid && (!emit || out_free);

   psfp_frame u_frame (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (item),
      .check (check)
   );

   psfp_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (emit && advance),
      .value      (check.value),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a good burst end always lands in the response register
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (emit && advance) |=> rsp_tvalid)
      else $error("accepted result did not reach the response register");

   // a new response only follows a burst end that moved on
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |->
         $past(advance && item.kind == psfp_pkg::KIND_BURST_END))
      else $error("response without a burst end");

   // an empty input register never backpressures
   a_in_ready: assert property (@(posedge clock) disable iff (reset)
      !item_valid |-> req_tready)
      else $error("request side stalled while input register empty");

endmodule
